### rtl/core/nrldi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nrldi_pkg;

    localparam int LLR_W         = 8;
    localparam int COL_W         = 14;
    localparam int MOD_W         = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 14;

    localparam int MAX_LLRS_DEF  = 16384;
    localparam int LLR_WIDTH_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MOD_ORDER    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [MOD_W-1:0] MOD_QPSK   = 2'd0;
    localparam logic [MOD_W-1:0] MOD_16QAM  = 2'd1;
    localparam logic [MOD_W-1:0] MOD_64QAM  = 2'd2;
    localparam logic [MOD_W-1:0] MOD_256QAM = 2'd3;

    typedef struct packed {
        logic signed [LLR_W-1:0] llr_in;
        logic                    drain_only;
    } in_item_t;

    typedef struct packed {
        logic signed [LLR_W-1:0] llr_out;
        logic                    last_of_block;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/core/nrldi_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nrldi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/nr_llr_bit_deinterleaver_top.sv
// A result item passes the RAM read register (p1) and the output register to m_*.
// One item per cycle unless m_ready stalls; RAM: one write and one read each cycle.
// Fill and drain always hit opposite banks, so no read can collide with a write.
// Reset (aresetn low, synchronous): counters, bank select, drain state and output
// stage clear, config to QPSK, one column; the bank RAM is not cleared, needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module nr_llr_bit_deinterleaver_top
    import nrldi_pkg::*;
#(
    parameter int MAX_LLRS  = MAX_LLRS_DEF,
    parameter int LLR_WIDTH = LLR_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item
);

    // offset bits inside one bank, drain count bits, sum width
    localparam int AW  = $clog2(MAX_LLRS);
    localparam int DRW = $clog2(MAX_LLRS + 1);
    localparam int SW  = ((AW > COL_W) ? AW : COL_W) + 1;
    // bits of an LLR that survive the store and the output
    localparam int CW  = (LLR_WIDTH < LLR_W) ? LLR_WIDTH : LLR_W;

    // column clamp per modulation order
    localparam int LIMIT_QM2 = MAX_LLRS / 2;
    localparam int LIMIT_QM4 = MAX_LLRS / 4;
    localparam int LIMIT_QM6 = MAX_LLRS / 6;
    localparam int LIMIT_QM8 = MAX_LLRS / 8;

    // configuration
    logic [MOD_W-1:0]  mod_order_reg,    mod_order_next;
    logic [COL_W-1:0]  column_count_reg, column_count_next;

    // fill side
    logic              fill_bank_reg,    fill_bank_next;
    logic [2:0]        row_cnt_reg,      row_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg,      col_cnt_next;
    logic [AW-1:0]     row_base_reg,     row_base_next;

    // drain side
    logic [DRW-1:0]    drain_rem_reg,    drain_rem_next;
    logic [AW-1:0]     drain_addr_reg,   drain_addr_next;

    // RAM read stage and output register
    logic              p1_valid_reg,     p1_valid_next;
    logic              p1_last_reg,      p1_last_next;
    logic              m_valid_reg,      m_valid_next;
    out_item_t         m_item_reg,       m_item_next;

    logic              accept;
    logic              do_drain;
    logic              do_fill;
    logic              p1_move;
    logic [COL_W-1:0]  col_min1;
    logic [SW-1:0]     col_limit;
    logic [COL_W-1:0]  k_eff;
    logic              row_last;
    logic              col_last;
    logic [SW-1:0]     wr_sum;
    logic [SW-1:0]     block_len;
    logic [AW:0]       ram_wr_addr;
    logic [AW:0]       ram_rd_addr;
    logic [LLR_WIDTH-1:0] ram_wr_data;
    logic [LLR_WIDTH-1:0] ram_rd_data;

    // effective column count: zero reads as one, clamp to the bank size
    always_comb begin
        col_min1 = (column_count_reg == '0) ? COL_W'(1) : column_count_reg;
        unique case (mod_order_reg)
            MOD_QPSK:  col_limit = SW'(LIMIT_QM2);
            MOD_16QAM: col_limit = SW'(LIMIT_QM4);
            MOD_64QAM: col_limit = SW'(LIMIT_QM6);
            default:   col_limit = SW'(LIMIT_QM8);
        endcase
        k_eff = (SW'(col_min1) > col_limit) ? col_limit[COL_W-1:0] : col_min1;
    end

    assign p1_move  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = aresetn && (!p1_valid_reg || p1_move);
    assign accept   = s_valid && s_ready;
    assign do_drain = accept && (drain_rem_reg != '0);
    assign do_fill  = accept && !s_item.drain_only;

    // last row index is Qm-1 = 2*mod_order+1
    assign row_last  = (row_cnt_reg == {mod_order_reg, 1'b1});
    assign col_last  = ((SW'(col_cnt_reg) + SW'(1)) >= SW'(k_eff));
    assign wr_sum    = SW'(row_base_reg) + SW'(col_cnt_reg);
    // at the final write the row base is (Qm-1)*K, so base + K is the block length
    assign block_len = SW'(row_base_reg) + SW'(k_eff);

    assign ram_wr_addr = {fill_bank_reg, wr_sum[AW-1:0]};
    assign ram_rd_addr = {~fill_bank_reg, drain_addr_reg};
    assign ram_wr_data = LLR_WIDTH'(s_item.llr_in[CW-1:0]);

    nrldi_ram #(
        .WIDTH (LLR_WIDTH),
        .DEPTH (2 << AW)
    ) u_bank_ram (
        .aclk    (aclk),
        .wr_en   (do_fill),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (do_drain),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        mod_order_next    = mod_order_reg;
        column_count_next = column_count_reg;
        fill_bank_next    = fill_bank_reg;
        row_cnt_next      = row_cnt_reg;
        col_cnt_next      = col_cnt_reg;
        row_base_next     = row_base_reg;
        drain_rem_next    = drain_rem_reg;
        drain_addr_next   = drain_addr_reg;
        p1_valid_next     = p1_valid_reg;
        p1_last_next      = p1_last_reg;
        m_valid_next      = m_valid_reg;
        m_item_next       = m_item_reg;

        // drain: issue the read, count down
        if (do_drain) begin
            drain_rem_next  = drain_rem_reg - DRW'(1);
            drain_addr_next = drain_addr_reg + AW'(1);
            p1_last_next    = (drain_rem_reg == DRW'(1));
        end

        // RAM data lands in p1; advance it into the output register
        if (do_drain) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end

        if (p1_move) begin
            m_valid_next               = 1'b1;
            m_item_next.llr_out        = LLR_W'(ram_rd_data[CW-1:0]);
            m_item_next.last_of_block  = p1_last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // register write abandons the partial block
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MOD_ORDER:    mod_order_next    = cfg_wr_data[MOD_W-1:0];
                REG_COLUMN_COUNT: column_count_next = cfg_wr_data[COL_W-1:0];
            endcase
            row_cnt_next  = '0;
            col_cnt_next  = '0;
            row_base_next = '0;
        end else if (do_fill) begin
            if (row_last) begin
                row_cnt_next  = '0;
                row_base_next = '0;
                if (col_last) begin
                    // block complete: swap banks, drop any leftover drain
                    col_cnt_next    = '0;
                    fill_bank_next  = ~fill_bank_reg;
                    drain_rem_next  = block_len[DRW-1:0];
                    drain_addr_next = '0;
                end else begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end else begin
                row_cnt_next  = row_cnt_reg + 3'd1;
                row_base_next = row_base_reg + AW'(k_eff);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_order_reg    <= '0;
            column_count_reg <= COL_W'(1);
            fill_bank_reg    <= 1'b0;
            row_cnt_reg      <= '0;
            col_cnt_reg      <= '0;
            row_base_reg     <= '0;
            drain_rem_reg    <= '0;
            drain_addr_reg   <= '0;
            p1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            mod_order_reg    <= mod_order_next;
            column_count_reg <= column_count_next;
            fill_bank_reg    <= fill_bank_next;
            row_cnt_reg      <= row_cnt_next;
            col_cnt_reg      <= col_cnt_next;
            row_base_reg     <= row_base_next;
            drain_rem_reg    <= drain_rem_next;
            drain_addr_reg   <= drain_addr_next;
            p1_valid_reg     <= p1_valid_next;
            m_valid_reg      <= m_valid_next;
        end
        // payload: no reset
        p1_last_reg <= p1_last_next;
        m_item_reg  <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

### rtl/core/nrldi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nrldi_checker
    import nrldi_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    // output stage comes out of reset empty
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a fresh result needs an accepted item that passed through the RAM read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input item");

    // with the output stage empty, p1 can always move on, so input must be open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage empty");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

endmodule

bind nr_llr_bit_deinterleaver_top nrldi_checker u_nrldi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nrldi_pkg::*;

    // Run plan: directed corner tests first, then two back-to-back blocks where
    // the second fill drains the first, then random phases of small blocks with
    // register changes in between. Reset once, at the start.
    localparam int RANDOM_ITEMS = 850;
    localparam int QUIET_TAIL   = 200;       // last random items run without idling
    localparam int CYCLE_LIMIT  = 6000000;   // far above the slowest legal run
    localparam int SETTLE_WAIT  = 4;         // pipeline is two stages deep
    localparam int BANK_SIZE    = MAX_LLRS_DEF;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;

    nr_llr_bit_deinterleaver_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // De-interleaver mirror: both banks plus the fill and drain counters.
    // ------------------------------------------------------------------
    logic [LLR_W-1:0] bank_mirror [0:2*BANK_SIZE-1];
    bit               fill_bank;
    int               fill_row;
    int               fill_col;
    int               fill_row_base;
    int               drain_left;
    int               drain_addr;
    logic [MOD_W-1:0] mod_reg;
    logic [COL_W-1:0] cols_reg;

    out_item_t        pending_llrs[$];   // de-interleaved LLRs still owed by the block
    out_item_t        oldest_llr;
    int               mismatches;
    int               cycles;
    bit               quiet;             // no idling on either side when set
    int               stall_left;

    // Advance the mirror by one accepted item: read the drain bank first,
    // then store the new LLR and step the row/column counters.
    function automatic void deinterleave_step(input in_item_t it);
        int        qm;
        int        k;
        int        addr;
        out_item_t res;
        qm = 2 + 2 * int'(mod_reg);
        k  = (cols_reg == '0) ? 1 : int'(cols_reg);
        if (k > BANK_SIZE / qm)
            k = BANK_SIZE / qm;       // clamp to what one bank holds
        if (drain_left > 0) begin
            res.llr_out = bank_mirror[(fill_bank ? 0 : BANK_SIZE) + drain_addr];
            drain_left--;
            drain_addr++;
            res.last_of_block = (drain_left == 0);
            pending_llrs.push_back(res);
        end
        if (!it.drain_only) begin
            addr = fill_row_base + fill_col;
            if (addr < BANK_SIZE)
                bank_mirror[(fill_bank ? BANK_SIZE : 0) + addr] = it.llr_in;
            if (fill_row + 1 >= qm) begin
                fill_row      = 0;
                fill_row_base = 0;
                if (fill_col + 1 >= k) begin
                    // block complete: swap banks, drop whatever was left to drain
                    fill_col   = 0;
                    fill_bank  = ~fill_bank;
                    drain_left = qm * k;
                    drain_addr = 0;
                end else begin
                    fill_col++;
                end
            end else begin
                fill_row++;
                fill_row_base += k;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Send one item, with an occasional idle burst ahead of it. Valid is left
    // high on return so back-to-back items keep it asserted.
    task automatic push_llr(input logic [LLR_W-1:0] llr, input logic drain);
        in_item_t it;
        int       gap;
        it.llr_in     = llr;
        it.drain_only = drain;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deinterleave_step(it);
    endtask

    // Drop valid, wait for every owed result, then give the pipeline time to
    // finish items that produce nothing.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_llrs.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // Write one register; any write restarts the partly filled block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MOD_ORDER)
            mod_reg = value[MOD_W-1:0];
        else
            cols_reg = value[COL_W-1:0];
        fill_row      = 0;
        fill_col      = 0;
        fill_row_base = 0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Reset values give Qm = 2, K = 1: two-entry blocks. Use the LLR extremes,
    // then flush, then one drain-only item with nothing left to drain.
    task automatic test_reset_defaults();
        push_llr(8'h7F, 1'b0);
        push_llr(8'h80, 1'b0);
        push_llr(8'h00, 1'b0);
        push_llr(8'hFF, 1'b0);
        push_llr(8'h55, 1'b1);
        push_llr(8'hAA, 1'b1);
        push_llr(8'h00, 1'b1);
    endtask

    // Fill an 8-entry block, then shrink to 2-entry blocks: the old block keeps
    // draining across the write and loses its tail at the next swap.
    task automatic test_drain_across_config();
        settle();
        write_reg(REG_MOD_ORDER, CFG_DATA_W'(MOD_256QAM));
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(1));
        repeat (8) push_llr(LLR_W'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(REG_MOD_ORDER, CFG_DATA_W'(MOD_QPSK));
        push_llr(LLR_W'($urandom_range(0, 255)), 1'b0);
        push_llr(LLR_W'($urandom_range(0, 255)), 1'b0);
        push_llr(8'h00, 1'b1);
        push_llr(8'h00, 1'b1);
    endtask

    // Leave a block half filled, rewrite the same value, and check the fill
    // restarts from position zero.
    task automatic test_abandon_fill();
        settle();
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(1));
        push_llr(8'h11, 1'b0);
        settle();
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(1));
        push_llr(8'h22, 1'b0);
        push_llr(8'h33, 1'b0);
        push_llr(8'h00, 1'b1);
        push_llr(8'h00, 1'b1);
    endtask

    // Column count zero behaves as one column.
    task automatic test_column_zero();
        settle();
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(0));
        push_llr(8'h40, 1'b0);
        push_llr(8'hC0, 1'b0);
        push_llr(8'h00, 1'b1);
        push_llr(8'h00, 1'b1);
    endtask

    // Two 128-entry blocks of different shape: the second fill drains the
    // first item for item, then a flush empties the second.
    task automatic test_block_handover();
        settle();
        write_reg(REG_MOD_ORDER, CFG_DATA_W'(MOD_QPSK));
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(64));
        repeat (128) push_llr(LLR_W'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(REG_MOD_ORDER, CFG_DATA_W'(MOD_256QAM));
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(16));
        repeat (128) push_llr(LLR_W'($urandom_range(0, 255)), 1'b0);
        repeat (128) push_llr(8'h00, 1'b1);
    endtask

    // Random phases: new settings, then a run of mostly fill items with some
    // flushes. Large column counts only see partial fills and get abandoned.
    task automatic test_random_blocks();
        int               counted;
        int               phase_len;
        int               pick;
        logic             drain;
        logic [CFG_DATA_W-1:0] cols;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            settle();
            quiet = (counted >= RANDOM_ITEMS - QUIET_TAIL);
            case ($urandom_range(0, 9))
                0:       cols = '0;
                1:       cols = CFG_DATA_W'($urandom_range(1000, 16383));
                default: cols = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            pick = $urandom_range(0, 2);
            if (pick != 1)
                write_reg(REG_MOD_ORDER, CFG_DATA_W'($urandom_range(0, 3)));
            if (pick != 0)
                write_reg(REG_COLUMN_COUNT, cols);
            phase_len = $urandom_range(8, 90);
            repeat (phase_len) begin
                drain = ($urandom_range(0, 4) == 0);
                // a flush with nothing to drain is a no-op; do not count it
                if (!drain || drain_left > 0)
                    counted++;
                push_llr(LLR_W'($urandom_range(0, 255)), drain);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts on m_ready, no new ones once quiet is set.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result against the oldest owed LLR.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_llrs.size() == 0) begin
                report_mismatch($sformatf("unexpected result llr %0d last %0d",
                                          m_item.llr_out, m_item.last_of_block));
            end else begin
                oldest_llr = pending_llrs.pop_front();
                if (m_item.llr_out !== oldest_llr.llr_out)
                    report_mismatch($sformatf("llr_out got %0d expected %0d",
                                              m_item.llr_out, oldest_llr.llr_out));
                if (m_item.last_of_block !== oldest_llr.last_of_block)
                    report_mismatch($sformatf("last_of_block got %0d expected %0d",
                                              m_item.last_of_block,
                                              oldest_llr.last_of_block));
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("nr_llr_bit_deinterleaver_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold every input at a known value and the mirror at reset state.
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= REG_MOD_ORDER;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_item        <= '0;
        m_ready       <= 1'b0;
        fill_bank     = 1'b0;
        fill_row      = 0;
        fill_col      = 0;
        fill_row_base = 0;
        drain_left    = 0;
        drain_addr    = 0;
        mod_reg       = '0;
        cols_reg      = COL_W'(1);
        mismatches    = 0;
        cycles        = 0;
        quiet         = 1'b0;
        stall_left    = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_drain_across_config();
        test_abandon_fill();
        test_column_zero();
        test_block_handover();
        test_random_blocks();

        // Drain what is owed, then keep watching for stray results.
        s_valid <= 1'b0;
        while (pending_llrs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("nr_llr_bit_deinterleaver_top verification clean");
        else
            $display("nr_llr_bit_deinterleaver_top verification failed");
        $finish;
    end

endmodule
